// ----- rtl/core/nas_pkg.sv -----
`timescale 1ns / 1ps

package nas_pkg;

    // Frame geometry limits and field widths
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int LVL_W    = 4;
    localparam int GLYPH_W  = 7;
    localparam int TDATA_W  = 24;
    localparam int SDATA_W  = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [LVL_W-1:0]  LVL_MAX       = 4'd9;
    localparam logic [SIZE_W-1:0] ROWS_RESET    = 7'd20;
    localparam logic [SIZE_W-1:0] COLS_RESET    = 7'd30;
    localparam logic [SIZE_W-1:0] SIZE_MIN      = 7'd2;
    localparam logic [SIZE_W-1:0] ROWS_LIMIT    = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_LIMIT    = SIZE_W'(MAX_COLS);

    // Register index (word address bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef logic [LVL_W-1:0] lvl_t;

    // Clamped frame size seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } size_t;

    // Results produced by one input pixel, handed to the output stage
    typedef struct packed {
        logic             have_a;
        logic             have_b;
        logic             have_d;
        lvl_t             lv;
        lvl_t             a_lvl;
        lvl_t             b_lvl;
        logic [ROW_W-1:0] a_row;
        logic [ROW_W-1:0] b_row;
        logic [COL_W-1:0] col;
    } res_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_MIN)
            r = SIZE_MIN;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Mean of cnt values (cnt 2..5), halves rounded up: (2*sum+cnt)/(2*cnt).
    // Divide by 6 and 10 via reciprocal multiply, exact for x < 128.
    function automatic lvl_t round_mean(input logic [5:0] sum, input logic [2:0] cnt);
        logic [6:0]  x;
        logic [14:0] prod;
        logic [6:0]  q;
        x    = {sum, 1'b0} + 7'(cnt);
        prod = '0;
        case (cnt)
            3'd3:
            begin
                prod = 15'(x) * 15'd43;
                q    = 7'(prod[14:8]);
            end
            3'd4:    q = x >> 3;
            3'd5:
            begin
                prod = 15'(x) * 15'd205;
                q    = 7'(prod[14:11]);
            end
            default: q = x >> 2;
        endcase
        return (q > 7'(LVL_MAX)) ? LVL_MAX : q[LVL_W-1:0];
    endfunction

    // Glyph table " .`:~*=+%#"
    function automatic logic [GLYPH_W-1:0] glyph_of(input lvl_t lvl);
        logic [GLYPH_W-1:0] g;
        case (lvl)
            4'd0:    g = 7'd32;   // space
            4'd1:    g = 7'd46;   // .
            4'd2:    g = 7'd96;   // `
            4'd3:    g = 7'd58;   // :
            4'd4:    g = 7'd126;  // ~
            4'd5:    g = 7'd42;   // *
            4'd6:    g = 7'd61;   // =
            4'd7:    g = 7'd43;   // +
            4'd8:    g = 7'd37;   // %
            default: g = 7'd35;   // #
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/core/nas_cfg.sv -----
`timescale 1ns / 1ps

module nas_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nas_pkg::APB_AW-1:0]     paddr,
    input  logic [nas_pkg::APB_DW-1:0]     pwdata,
    output logic [nas_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    output nas_pkg::size_t                 size,
    output logic                           restart
);

    logic [nas_pkg::SIZE_W-1:0] frame_rows_reg;
    logic [nas_pkg::SIZE_W-1:0] frame_cols_reg;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // any write transaction restarts the frame
    assign restart = wr_en;

    // Register file, word addressed by paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= nas_pkg::ROWS_RESET;
            frame_cols_reg <= nas_pkg::COLS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                nas_pkg::REG_ROWS: frame_rows_reg <= pwdata[nas_pkg::SIZE_W-1:0];
                nas_pkg::REG_COLS: frame_cols_reg <= pwdata[nas_pkg::SIZE_W-1:0];
                default:           frame_rows_reg <= frame_rows_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            nas_pkg::REG_ROWS: prdata = nas_pkg::APB_DW'(frame_rows_reg);
            nas_pkg::REG_COLS: prdata = nas_pkg::APB_DW'(frame_cols_reg);
            default:           prdata = '0;
        endcase
    end

    assign size.rows = nas_pkg::clamp_size(frame_rows_reg, nas_pkg::ROWS_LIMIT);
    assign size.cols = nas_pkg::clamp_size(frame_cols_reg, nas_pkg::COLS_LIMIT);

endmodule

// ----- rtl/core/nas_core.sv -----
`timescale 1ns / 1ps

module nas_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            restart,
    input  nas_pkg::size_t                  size,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nas_pkg::SDATA_W-1:0]     s_tdata,
    input  logic                            emit_busy,
    output nas_pkg::res_t                   res,
    output logic                            res_valid
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_CALC = 1'b1;

    localparam int CW = nas_pkg::COL_W;
    localparam int RW = nas_pkg::ROW_W;

    // Line memories: original row above and smoothed row above
    nas_pkg::lvl_t orig_mem [nas_pkg::MAX_COLS];
    nas_pkg::lvl_t sm_mem   [nas_pkg::MAX_COLS];

    logic [0:0]    state_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    nas_pkg::lvl_t left_reg, prev_reg, bprev_reg;

    // item registers
    nas_pkg::lvl_t lv_reg, ocur_reg, orig_rd_reg, sm_rd_reg;
    logic [RW-1:0] r_item_reg;
    logic [CW-1:0] c_item_reg;

    logic          accept;
    nas_pkg::lvl_t lv_in;
    logic          c_last_in, r_last_in;
    logic [CW-1:0] orig_raddr;

    logic          it_c_last, it_r_last;
    logic          it_r_pos, it_r_gt1, it_c_pos, it_c_gt1;
    logic          have_a, have_b, have_d;
    logic [5:0]    sum_a, sum_b;
    logic [2:0]    cnt_a, cnt_b;
    nas_pkg::lvl_t a_lvl, b_lvl;

    assign s_tready = (state_reg == ST_IDLE) && !emit_busy;
    assign accept   = s_tvalid && s_tready;

    // Saturate level to nine
    assign lv_in = (s_tdata[nas_pkg::LVL_W-1:0] > nas_pkg::LVL_MAX) ?
                   nas_pkg::LVL_MAX : s_tdata[nas_pkg::LVL_W-1:0];

    // Raster position of the incoming pixel
    assign c_last_in  = ({1'b0, col_reg} == size.cols - 7'd1);
    assign r_last_in  = ({1'b0, row_reg} == size.rows - 7'd1);
    assign col_next   = c_last_in ? '0 : col_reg + CW'(1);
    assign row_next   = c_last_in ? (r_last_in ? '0 : row_reg + RW'(1)) : row_reg;
    // right neighbour of the current pixel, kept as the next pixel's own; at row end prefetch column 0
    assign orig_raddr = c_last_in ? '0 : col_reg + CW'(1);

    // Memory access: write original at accept, read original one column ahead, smoothed at this column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            orig_mem[col_reg] <= lv_in;
            orig_rd_reg       <= orig_mem[orig_raddr];
            sm_rd_reg         <= sm_mem[col_reg];
        end
        if (state_reg == ST_CALC && have_a)
            sm_mem[c_item_reg] <= a_lvl;
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lv_reg     <= lv_in;
            r_item_reg <= row_reg;
            c_item_reg <= col_reg;
        end
        if (state_reg == ST_CALC)
            ocur_reg <= orig_rd_reg;
    end

    // Item position flags
    assign it_c_last = ({1'b0, c_item_reg} == size.cols - 7'd1);
    assign it_r_last = ({1'b0, r_item_reg} == size.rows - 7'd1);
    assign it_r_pos  = (r_item_reg != '0);
    assign it_r_gt1  = (r_item_reg > RW'(1));
    assign it_c_pos  = (c_item_reg != '0);
    assign it_c_gt1  = (c_item_reg > CW'(1));

    assign have_a = it_r_pos;
    assign have_b = it_r_last && it_c_pos;
    assign have_d = have_b && it_c_last;

    // Pixel one row up: up is smoothed, left is smoothed, down/right original
    always_comb
    begin
        sum_a = 6'(ocur_reg) + 6'(lv_reg);
        cnt_a = 3'd2;
        if (it_r_gt1)
        begin
            sum_a = sum_a + 6'(sm_rd_reg);
            cnt_a = cnt_a + 3'd1;
        end
        if (it_c_pos)
        begin
            sum_a = sum_a + 6'(left_reg);
            cnt_a = cnt_a + 3'd1;
        end
        if (!it_c_last)
        begin
            sum_a = sum_a + 6'(orig_rd_reg);
            cnt_a = cnt_a + 3'd1;
        end
    end

    // Last row, pixel to the left: up is the previous left value
    always_comb
    begin
        sum_b = 6'(prev_reg) + 6'(lv_reg) + 6'(left_reg);
        cnt_b = 3'd3;
        if (it_c_gt1)
        begin
            sum_b = sum_b + 6'(bprev_reg);
            cnt_b = 3'd4;
        end
    end

    assign a_lvl = nas_pkg::round_mean(sum_a, cnt_a);
    assign b_lvl = nas_pkg::round_mean(sum_b, cnt_b);

    // Control and carried state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
            prev_reg  <= '0;
            bprev_reg <= '0;
        end
        else if (restart)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
            prev_reg  <= '0;
            bprev_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        row_reg   <= row_next;
                        col_reg   <= col_next;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (have_a)
                        left_reg <= a_lvl;
                    bprev_reg <= b_lvl;
                    prev_reg  <= lv_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Hand results to the output stage
    assign res_valid  = (state_reg == ST_CALC) && (have_a || have_b);
    assign res.have_a = have_a;
    assign res.have_b = have_b;
    assign res.have_d = have_d;
    assign res.lv     = lv_reg;
    assign res.a_lvl  = a_lvl;
    assign res.b_lvl  = b_lvl;
    assign res.a_row  = r_item_reg - RW'(1);
    assign res.b_row  = r_item_reg;
    assign res.col    = c_item_reg;

endmodule

// ----- rtl/core/nas_emit.sv -----
`timescale 1ns / 1ps

module nas_emit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  nas_pkg::res_t                   res,
    input  logic                            res_valid,
    output logic                            busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nas_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast
);

    localparam int PAD_W = nas_pkg::TDATA_W - nas_pkg::GLYPH_W
                           - nas_pkg::COL_W - nas_pkg::ROW_W;

    logic [2:0]                      pend_reg, pend_next;
    nas_pkg::res_t                   batch_reg;
    logic                            out_valid_reg;
    logic [nas_pkg::TDATA_W-1:0]     out_data_reg;
    logic                            out_last_reg;

    logic                            load_ok;
    logic [5:0]                      sum_d;
    nas_pkg::lvl_t                   d_lvl, sel_lvl;
    logic [nas_pkg::ROW_W-1:0]       sel_row;
    logic [nas_pkg::COL_W-1:0]       sel_col;
    logic                            sel_last;

    assign busy    = |pend_reg;
    assign load_ok = !out_valid_reg || m_tready;

    // Corner pixel: up (a) and left (b) of this batch plus its own level
    assign sum_d = 6'(batch_reg.lv) + 6'(batch_reg.a_lvl) + 6'(batch_reg.b_lvl);
    assign d_lvl = nas_pkg::round_mean(sum_d, 3'd3);

    // Pick the next pending result in raster order
    always_comb
    begin
        sel_lvl   = d_lvl;
        sel_row   = batch_reg.b_row;
        sel_col   = batch_reg.col;
        sel_last  = 1'b1;
        pend_next = 3'b000;
        if (pend_reg[0])
        begin
            sel_lvl   = batch_reg.a_lvl;
            sel_row   = batch_reg.a_row;
            sel_last  = 1'b0;
            pend_next = {pend_reg[2:1], 1'b0};
        end
        else if (pend_reg[1])
        begin
            sel_lvl   = batch_reg.b_lvl;
            sel_col   = batch_reg.col - nas_pkg::COL_W'(1);
            sel_last  = 1'b0;
            pend_next = {pend_reg[2], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            batch_reg <= res;
        if (load_ok && busy)
        begin
            out_data_reg <= {PAD_W'(0), nas_pkg::glyph_of(sel_lvl), sel_col, sel_row};
            out_last_reg <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid)
                pend_reg <= {res.have_d, res.have_b, res.have_a};
            else if (load_ok && busy)
                pend_reg <= pend_next;
            if (load_ok)
                out_valid_reg <= busy;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/neighbor_average_smoother.sv -----
`timescale 1ns / 1ps
// The first result of a pixel passes the item registers and the batch register into the output
// register, where output backpressure can hold it. A new pixel is taken only once the previous
// one has finished its read-compute-writeback pass over the line memories and all of its results
// have left the batch register for the output register; output backpressure delays this.
// Reset: async active low; frame 20 x 30, raster position and carried levels cleared,
// line memories are not cleared (each entry is written before it is read).

module neighbor_average_smoother
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nas_pkg::APB_AW-1:0]      paddr,
    input  logic [nas_pkg::APB_DW-1:0]      pwdata,
    output logic [nas_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nas_pkg::SDATA_W-1:0]     s_tdata,   // [3:0] pixel_level, [7:4] zero
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nas_pkg::TDATA_W-1:0]     m_tdata,   // [5:0] out_row, [11:6] out_col,
                                                       // [18:12] glyph, [23:19] zero
    output logic                            m_tlast    // end_of_frame
);

    nas_pkg::size_t size;
    nas_pkg::res_t  res;
    logic           restart;
    logic           res_valid;
    logic           emit_busy;

    nas_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .size    (size),
        .restart (restart)
    );

    nas_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .size      (size),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .emit_busy (emit_busy),
        .res       (res),
        .res_valid (res_valid)
    );

    nas_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .busy      (emit_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/core/nas_checker.sv -----
`timescale 1ns / 1ps

module nas_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nas_pkg::TDATA_W-1:0]     m_tdata,
    input logic                            m_tlast
);

    // stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // one pixel at a time: no input transaction right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous pixel in flight");

    // glyph is printable and padding is zero
    a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[18:12] >= 7'd32 && m_tdata[18:12] <= 7'd126
                     && m_tdata[23:19] == 5'd0)
        else $error("bad glyph or padding");

    // frame end lies past row 0 and column 0
    a_eof_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[5:0] != 6'd0 && m_tdata[11:6] != 6'd0)
        else $error("end of frame at impossible position");

endmodule

bind neighbor_average_smoother nas_checker u_nas_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- verif/neighbor_average_smoother_tb.sv -----
`timescale 1ns / 1ps

module neighbor_average_smoother_tb;

    import nas_pkg::*;

    localparam int IDLE_PCT      = 18;   // chance of an idle cycle on either side
    localparam int LONG_HOLD     = 150;  // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 12;   // covers an in-flight pixel that emits nothing
    localparam int SMALL_TARGET  = 30;   // least number of pixels sent in the small random frames

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
    localparam logic [GLYPH_W-1:0] GLYPH_HASH  = 7'd35;
    localparam logic [GLYPH_W-1:0] GLYPH_NONE  = 7'd0;

    typedef enum logic [1:0]
    {
        STEP_PIXEL,
        STEP_SET_ROWS,
        STEP_SET_COLS
    } step_kind_t;

    typedef struct packed
    {
        step_kind_t         kind;
        logic [31:0]        value;
        logic [GLYPH_W-1:0] want_glyph;   // GLYPH_NONE: predicted
    } step_t;

    typedef struct packed
    {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic               eof;
    } pixel_result_t;

    localparam int N_DIRECTED = 21;

    // Directed sequence: size clamps, saturation, uniform frames, a 3 x 2 frame
    step_t directed_steps [N_DIRECTED] = '{
        '{STEP_SET_ROWS, 32'd0,  GLYPH_NONE},
        '{STEP_SET_COLS, 32'd1,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd15, GLYPH_HASH},
        '{STEP_PIXEL,    32'd15, GLYPH_HASH},
        '{STEP_PIXEL,    32'd15, GLYPH_HASH},
        '{STEP_PIXEL,    32'd15, GLYPH_HASH},
        '{STEP_PIXEL,    32'd0,  GLYPH_SPACE},
        '{STEP_PIXEL,    32'd0,  GLYPH_SPACE},
        '{STEP_PIXEL,    32'd0,  GLYPH_SPACE},
        '{STEP_PIXEL,    32'd0,  GLYPH_SPACE},
        '{STEP_PIXEL,    32'd10, GLYPH_HASH},
        '{STEP_PIXEL,    32'd11, GLYPH_HASH},
        '{STEP_PIXEL,    32'd12, GLYPH_HASH},
        '{STEP_PIXEL,    32'd13, GLYPH_HASH},
        '{STEP_SET_ROWS, 32'd3,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd9,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd0,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd0,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd9,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd4,  GLYPH_NONE},
        '{STEP_PIXEL,    32'd14, GLYPH_NONE}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDATA_W-1:0]  s_tdata;     // [3:0] pixel_level, [7:4] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;     // [5:0] out_row, [11:6] out_col, [18:12] glyph, [23:19] zero
    logic                m_tlast;     // end_of_frame

    // Predictor state
    logic [SIZE_W-1:0]   rows_reg;
    logic [SIZE_W-1:0]   cols_reg;
    lvl_t                orig_line   [MAX_COLS];
    lvl_t                smooth_line [MAX_COLS];
    lvl_t                left_level;
    lvl_t                prev_level;
    int unsigned         pos_row;
    int unsigned         pos_col;
    logic [GLYPH_W-1:0]  typed_glyph = GLYPH_NONE;

    pixel_result_t       awaited_results [$];

    int                  mismatches  = 0;
    int                  pixels_in   = 0;
    int                  results_in  = 0;
    int                  frames_seen = 0;
    bit                  no_idle     = 1'b0;
    bit                  hold_pending = 1'b0;

    neighbor_average_smoother DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned frame_extent(input logic [SIZE_W-1:0] v,
                                                 input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Rounded mean, halves up, capped at the top level
    function automatic lvl_t mean_level(input int unsigned sum, input int unsigned cnt);
        int unsigned m;
        m = (2 * sum + cnt) / (2 * cnt);
        return (m > LVL_MAX) ? LVL_MAX : lvl_t'(m);
    endfunction

    // Glyphs: space . backtick : ~ * = + % #
    function automatic logic [GLYPH_W-1:0] level_glyph(input lvl_t lvl);
        case (lvl)
            4'd0:    return 7'd32;
            4'd1:    return 7'd46;
            4'd2:    return 7'd96;
            4'd3:    return 7'd58;
            4'd4:    return 7'd126;
            4'd5:    return 7'd42;
            4'd6:    return 7'd61;
            4'd7:    return 7'd43;
            4'd8:    return 7'd37;
            default: return 7'd35;
        endcase
    endfunction

    task automatic queue_result(input int unsigned r, input int unsigned c,
                                input lvl_t lvl, input logic eof);
        pixel_result_t res;
        res.row   = ROW_W'(r);
        res.col   = COL_W'(c);
        res.glyph = (typed_glyph != GLYPH_NONE) ? typed_glyph : level_glyph(lvl);
        res.eof   = eof;
        awaited_results.push_back(res);
    endtask

    // In-place five-point smoothing with one row of lookahead
    task automatic smooth_pixel(input lvl_t raw);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned lv;
        int unsigned sum;
        int unsigned cnt;
        lvl_t        a;
        lvl_t        b;
        lvl_t        d;
        rows = frame_extent(rows_reg, MAX_ROWS);
        cols = frame_extent(cols_reg, MAX_COLS);
        r    = pos_row;
        c    = pos_col;
        lv   = (raw > LVL_MAX) ? LVL_MAX : raw;
        if (r >= rows || c >= cols)
        begin
            r = 0;
            c = 0;
        end

        // pixel above, completed by this input
        if (r > 0)
        begin
            sum = orig_line[c] + lv;
            cnt = 2;
            if (r > 1)
            begin
                sum += smooth_line[c];
                cnt++;
            end
            if (c > 0)
            begin
                sum += left_level;
                cnt++;
            end
            if (c + 1 < cols)
            begin
                sum += orig_line[c + 1];
                cnt++;
            end
            a              = mean_level(sum, cnt);
            smooth_line[c] = a;
            left_level     = a;
            queue_result(r - 1, c, a, 1'b0);
        end

        // last row: left neighbor, and the final pixel at the frame end
        if (r == rows - 1 && c > 0)
        begin
            sum = prev_level + lv + smooth_line[c - 1];
            cnt = 3;
            if (c > 1)
            begin
                sum += smooth_line[c - 2];
                cnt++;
            end
            b                  = mean_level(sum, cnt);
            smooth_line[c - 1] = b;
            queue_result(r, c - 1, b, 1'b0);
            if (c == cols - 1)
            begin
                d              = mean_level(lv + smooth_line[c] + smooth_line[c - 1], 3);
                smooth_line[c] = d;
                queue_result(r, c, d, 1'b1);
            end
        end

        orig_line[c] = lvl_t'(lv);
        prev_level   = lvl_t'(lv);
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        pos_row = r;
        pos_col = c;
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic apb_transfer(input logic write, input logic idx,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_register(input logic idx);
        logic [APB_DW-1:0] got;
        apb_transfer(1'b0, idx, '0, got);
        check_field((idx == REG_ROWS) ? "frame_rows" : "frame_cols",
                    APB_DW'((idx == REG_ROWS) ? rows_reg : cols_reg), got);
    endtask

    // Stop offering pixels and let every pending result come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write restarts the frame; only done with the block idle
    task automatic set_frame_reg(input logic idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused;
        drain_results();
        apb_transfer(1'b1, idx, value, unused);
        if (idx == REG_ROWS)
            rows_reg = value[SIZE_W-1:0];
        else
            cols_reg = value[SIZE_W-1:0];
        pos_row    = 0;
        pos_col    = 0;
        left_level = '0;
        prev_level = '0;
        check_register(idx);
    endtask

    task automatic send_pixel(input lvl_t level);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDATA_W - LVL_W){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_tready);
        smooth_pixel(level);
        pixels_in++;
    endtask

    // Mostly in-range levels, some that saturate
    function automatic lvl_t noisy_level();
        if ($urandom_range(0, 99) < 25)
            return lvl_t'($urandom_range(10, 15));
        return lvl_t'($urandom_range(0, 9));
    endfunction

    // Small frame size, sometimes below the minimum; upper bus bits are noise
    function automatic logic [APB_DW-1:0] pick_extent();
        logic [SIZE_W-1:0] v;
        if ($urandom_range(0, 9) == 0)
            v = SIZE_W'($urandom_range(0, 1));
        else
            v = SIZE_W'($urandom_range(2, 5));
        return ($urandom() & ~APB_DW'(7'h7F)) | APB_DW'(v);
    endfunction

    // ---------------------------------------------------------------- result side

    initial
    begin
        int            hold_left;
        pixel_result_t want;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                results_in++;
                if (m_tlast)
                    frames_seen++;
                if (awaited_results.size() == 0)
                begin
                    $error("result with nothing pending: row %0d col %0d",
                           m_tdata[5:0], m_tdata[11:6]);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("out_row", want.row, m_tdata[5:0]);
                    check_field("out_col", want.col, m_tdata[11:6]);
                    check_field("glyph", want.glyph, m_tdata[18:12]);
                    check_field("end_of_frame", want.eof, m_tlast);
                end
            end
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        int unsigned n;
        int          small_sent;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rows_reg   = ROWS_RESET;
        cols_reg   = COLS_RESET;
        pos_row    = 0;
        pos_col    = 0;
        left_level = '0;
        prev_level = '0;
        small_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the size registers
        check_register(REG_ROWS);
        check_register(REG_COLS);

        foreach (directed_steps[i])
        begin
            case (directed_steps[i].kind)
                STEP_SET_ROWS: set_frame_reg(REG_ROWS, directed_steps[i].value);
                STEP_SET_COLS: set_frame_reg(REG_COLS, directed_steps[i].value);
                default:
                begin
                    typed_glyph = directed_steps[i].want_glyph;
                    send_pixel(lvl_t'(directed_steps[i].value));
                end
            endcase
        end
        typed_glyph = GLYPH_NONE;

        // backpressure: long receiver hold, then a sender pause mid-frame
        set_frame_reg(REG_ROWS, 32'd4);
        set_frame_reg(REG_COLS, 32'd6);
        hold_pending = 1'b1;
        repeat (18) send_pixel(noisy_level());
        drain_results();
        repeat (6) send_pixel(noisy_level());

        // tall frame cut short, no idling on either side
        no_idle = 1'b1;
        set_frame_reg(REG_ROWS, 32'd127);
        set_frame_reg(REG_COLS, 32'd2);
        repeat (20) send_pixel(noisy_level());

        // widest frame at the row minimum, one full row and part of the next
        set_frame_reg(REG_ROWS, 32'd1);
        set_frame_reg(REG_COLS, 32'd127);
        repeat (MAX_COLS + 8) send_pixel(noisy_level());
        no_idle = 1'b0;

        // small random frames, often cut short by the next size change
        while (small_sent < SMALL_TARGET)
        begin
            set_frame_reg(REG_ROWS, pick_extent());
            set_frame_reg(REG_COLS, pick_extent());
            n = frame_extent(rows_reg, MAX_ROWS) * frame_extent(cols_reg, MAX_COLS)
                * $urandom_range(1, 2) + $urandom_range(0, frame_extent(cols_reg, MAX_COLS));
            repeat (n) send_pixel(noisy_level());
            small_sent += n;
        end

        drain_results();
        $display("Coverage: %0d pixels sent, %0d smoothed results checked, %0d frames ended",
                 pixels_in, results_in, frames_seen);
        $display("Sizes clamped at both ends, saturated levels, long output stalls and pauses");
        if (mismatches == 0)
            $display("neighbor_average_smoother_tb OK");
        else
            $display("neighbor_average_smoother_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("neighbor_average_smoother_tb NOT OK");
        $finish;
    end

endmodule
